@@ rtl/core/pes_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic event scheduler package
// Shared types and constants for the scheduler core.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned DueW    = 48;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] period;
    logic [DueW-1:0]    due;
  } entry_t;

  typedef struct packed {
    logic decode;
    logic scan;
    logic update;
    logic load_out;
  } pes_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } pes_stat_t;

endpackage

@@ rtl/core/pes_if.sv @@
// ----------------------------------------------------------------------------
// Periodic event scheduler channels
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface pes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] source_id;
  logic [15:0] period;

  modport source (output valid, mode, source_id, period, input ready);
  modport sink   (input valid, mode, source_id, period, output ready);
endinterface

interface pes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] event_id;

  modport source (output valid, status, event_id, input ready);
  modport sink   (input valid, status, event_id, output ready);
endinterface

@@ rtl/core/pes_dp.sv @@
// ----------------------------------------------------------------------------
// Periodic event scheduler datapath
// Source table memory, entry count, minimum search and result registers.
// ----------------------------------------------------------------------------
module pes_dp import pes_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pes_cmd_t          cmd_i,
  output pes_stat_t         stat_o,
  input  logic [1:0]        mode_i,
  input  logic [IdW-1:0]    source_id_i,
  input  logic [PeriodW-1:0] period_i,
  output logic [1:0]        status_o,
  output logic [IdW-1:0]    event_id_o
);

  localparam int unsigned AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned CW = $clog2(MAX_SOURCES + 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_SOURCES);

  entry_t mem [MAX_SOURCES];
  entry_t rd_q;

  logic [CW-1:0]      count_q, idx_q, pidx_q;
  logic               pend_q;
  logic [1:0]         mode_q;
  logic [IdW-1:0]     sid_q;
  logic [PeriodW-1:0] per_q;
  entry_t             best_q;
  logic [AW-1:0]      best_idx_q;
  status_e            res_status_q;
  logic [IdW-1:0]     res_id_q;
  logic [1:0]         out_status_q;
  logic [IdW-1:0]     out_id_q;

  logic    wr_en;
  logic [AW-1:0] wr_addr;
  entry_t  wr_data;
  logic    take;

  always_ff @(posedge clk_i) begin
    mode_q <= mode_i;
    sid_q  <= source_id_i;
    per_q  <= period_i;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = '{id: sid_q, period: per_q, due: DueW'(per_q)};
    if (cmd_i.decode && mode_e'(mode_q) == MODE_ADD && count_q != CountMax) begin
      wr_en = 1'b1;
    end else if (cmd_i.update) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_q;
      wr_data = '{id: best_q.id, period: best_q.period,
                  due: best_q.due + DueW'(best_q.period)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  assign take = (pidx_q == '0) || (rd_q.due < best_q.due) ||
                (rd_q.due == best_q.due && rd_q.id < best_q.id);

  assign stat_o.needs_scan = (mode_e'(mode_q) == MODE_NEXT) && (count_q != '0);
  assign stat_o.scan_last  = pend_q && (pidx_q == count_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pidx_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        if (mode_e'(mode_q) == MODE_CLEAR) begin
          count_q <= '0;
        end else if (wr_en) begin
          count_q <= count_q + CW'(1);
        end
      end else if (cmd_i.scan) begin
        pidx_q <= idx_q;
        pend_q <= idx_q < count_q;
        if (idx_q < count_q) begin
          idx_q <= idx_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && pend_q && take) begin
      best_q     <= rd_q;
      best_idx_q <= pidx_q[AW-1:0];
    end
    if (cmd_i.decode) begin
      res_id_q <= '0;
      unique case (mode_e'(mode_q))
        MODE_ADD:  res_status_q <= (count_q == CountMax) ? STATUS_FULL : STATUS_OK;
        MODE_NEXT: res_status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_OK;
        default:   res_status_q <= STATUS_OK;
      endcase
    end
    if (cmd_i.update) begin
      res_id_q <= best_q.id;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
    end
  end

  assign status_o   = out_status_q;
  assign event_id_o = out_id_q;

endmodule

@@ rtl/core/pes_ctrl.sv @@
// ----------------------------------------------------------------------------
// Periodic event scheduler controller
// Sequences decode, table search, due time update and result hand-off.
// ----------------------------------------------------------------------------
module pes_ctrl import pes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pes_cmd_t  cmd_o,
  input  pes_stat_t stat_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d = stat_i.needs_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE) else $error("accept lost");
  a_legal_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= S_FINISH) else $error("illegal state");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q) else $error("result not presented");
`endif

endmodule

@@ rtl/core/periodic_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic event scheduler
// A clear, add or unused-mode transaction, or a next transaction on an empty
// table, goes from decode straight to its result; a next transaction on a
// non-empty table first searches the source table memory, one entry per
// cycle through its single registered read port, and then updates the due
// time of the entry found. One transaction is handled at a time; a result
// waits in an output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module periodic_event_scheduler import pes_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pes_in_if.sink    in_i,
  pes_out_if.source out_o
);

  pes_cmd_t  cmd;
  pes_stat_t stat;

  pes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pes_dp #(.MAX_SOURCES(MAX_SOURCES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (in_i.mode),
    .source_id_i (in_i.source_id),
    .period_i    (in_i.period),
    .status_o    (out_o.status),
    .event_id_o  (out_o.event_id)
  );

endmodule
